/* design/miou_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miou_pkg - shared widths and constants for the max IoU unit
// Coordinate, area and fraction widths, plus the threshold reset value.
// ----------------------------------------------------------------------------
package miou_pkg;

	// input geometry
	localparam int COORD_BITS = 13;
	localparam int SIZE_BITS  = COORD_BITS - 1;
	// coordinate math with headroom for right edge and differences
	localparam int EXT_W      = COORD_BITS + 2;
	// clamped side length (ground-truth side may span the whole range)
	localparam int LEN_W      = COORD_BITS;
	localparam int AREA_W     = 2 * LEN_W;
	localparam int UNI_W      = AREA_W + 1;
	// cross products for the ratio compare
	localparam int PROD_W     = AREA_W + UNI_W;

	// output fraction
	localparam int FRACTION_BITS = 16;
	localparam int OUT_BITS      = FRACTION_BITS + 1;
	localparam int REM_W         = UNI_W + 1;

	// step counter covers the longest serial pass
	localparam int MAX_STEPS = (UNI_W > OUT_BITS) ? UNI_W : OUT_BITS;
	localparam int CNT_W     = $clog2(MAX_STEPS + 1);

	// threshold register reset, about 0.3 in Q1.16
	localparam logic [OUT_BITS-1:0] THRESH_RESET = OUT_BITS'(19661);

endpackage

/* design/max_iou_against_box_set_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_iou_against_box_set_unit - best IoU of one detection over a box group
//
// Input channel (in_valid / in_ready): one transaction carries a detection
// rectangle, one ground-truth box and a last_box mark. Output channel
// (out_valid / out_ready): one transaction per group, issued for the item
// that carries last_box, with max_iou (unsigned Q1.16) and below_threshold.
// Configuration: cfg_wr_en / cfg_wr_data write iou_threshold.
//
// Timing: all multiplies and the final division run one bit per cycle.
// An item passes an accept step, serial area products, a union step,
// serial cross products and a decide step. A last item adds a restoring
// division and an output step. The bit-serial shift-add datapath keeps
// one item in flight at a time.
//
// Reset: best pair returns to 0/1 (ratio zero), threshold to 19661, no
// transaction pending. If the receiver stalls, the result stays in the
// output register; new items are still taken and only a following group
// end waits for the register to drain.
// ----------------------------------------------------------------------------
module max_iou_against_box_set_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [miou_pkg::COORD_BITS-1:0] det_x,
	input  logic signed [miou_pkg::COORD_BITS-1:0] det_y,
	input  logic        [miou_pkg::SIZE_BITS-1:0]  det_width,
	input  logic        [miou_pkg::SIZE_BITS-1:0]  det_height,
	input  logic signed [miou_pkg::COORD_BITS-1:0] gt_left,
	input  logic signed [miou_pkg::COORD_BITS-1:0] gt_top,
	input  logic signed [miou_pkg::COORD_BITS-1:0] gt_right,
	input  logic signed [miou_pkg::COORD_BITS-1:0] gt_bottom,
	input  logic                                  last_box,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic        [miou_pkg::OUT_BITS-1:0]   max_iou,
	output logic                                  below_threshold,
	// threshold register
	input  logic                                  cfg_wr_en,
	input  logic        [miou_pkg::OUT_BITS-1:0]   cfg_wr_data
);

	localparam int EXT_W    = miou_pkg::EXT_W;
	localparam int LEN_W    = miou_pkg::LEN_W;
	localparam int AREA_W   = miou_pkg::AREA_W;
	localparam int UNI_W    = miou_pkg::UNI_W;
	localparam int PROD_W   = miou_pkg::PROD_W;
	localparam int OUT_BITS = miou_pkg::OUT_BITS;
	localparam int REM_W    = miou_pkg::REM_W;
	localparam int CNT_W    = miou_pkg::CNT_W;

	// sequencer codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_AREA   = 3'd1;
	localparam logic [2:0] ST_UNION  = 3'd2;
	localparam logic [2:0] ST_CMP    = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;
	localparam logic [2:0] ST_DIV    = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             last_q;
	logic [OUT_BITS-1:0] thr_q;

	// side lengths; the *h registers double as multiplier shift lines
	logic [LEN_W-1:0] iw_q, ih_q, dw_q, dh_q, gw_q, gh_q;
	// area accumulators: intersection, detection, ground truth
	logic [AREA_W-1:0] ii_q, dd_q, gg_q;
	logic [UNI_W-1:0]  uni_q;

	// best pair so far
	logic [AREA_W-1:0] bi_q;
	logic [UNI_W-1:0]  bu_q;

	// cross-product shift lines and accumulators
	logic [UNI_W-1:0]  mb_q, mu_q;
	logic [PROD_W-1:0] acc_a_q, acc_b_q;

	// divider
	logic [REM_W-1:0]    rem_q;
	logic [OUT_BITS-1:0] quot_q;

	// output register
	logic                out_valid_q;
	logic [OUT_BITS-1:0] max_iou_q;
	logic                below_q;

	// ---------------------------------------------------------------------
	// Edge geometry at accept: clamp negative spans to zero
	// ---------------------------------------------------------------------
	logic signed [EXT_W-1:0] dx1_e, dy1_e, dx2_e, dy2_e;
	logic signed [EXT_W-1:0] gx1_e, gy1_e, gx2_e, gy2_e;
	logic signed [EXT_W-1:0] ix_lo, ix_hi, iy_lo, iy_hi;
	logic signed [EXT_W-1:0] iw_d, ih_d, gw_d, gh_d;
	logic [LEN_W-1:0]        iw_c, ih_c, gw_c, gh_c;

	always_comb begin
		dx1_e = EXT_W'(det_x);
		dy1_e = EXT_W'(det_y);
		gx1_e = EXT_W'(gt_left);
		gy1_e = EXT_W'(gt_top);
		gx2_e = EXT_W'(gt_right);
		gy2_e = EXT_W'(gt_bottom);
		dx2_e = dx1_e + $signed(EXT_W'(det_width));
		dy2_e = dy1_e + $signed(EXT_W'(det_height));

		ix_lo = (dx1_e > gx1_e) ? dx1_e : gx1_e;
		ix_hi = (dx2_e < gx2_e) ? dx2_e : gx2_e;
		iy_lo = (dy1_e > gy1_e) ? dy1_e : gy1_e;
		iy_hi = (dy2_e < gy2_e) ? dy2_e : gy2_e;

		iw_d = ix_hi - ix_lo;
		ih_d = iy_hi - iy_lo;
		gw_d = gx2_e - gx1_e;
		gh_d = gy2_e - gy1_e;

		iw_c = iw_d[EXT_W-1] ? '0 : iw_d[LEN_W-1:0];
		ih_c = ih_d[EXT_W-1] ? '0 : ih_d[LEN_W-1:0];
		gw_c = gw_d[EXT_W-1] ? '0 : gw_d[LEN_W-1:0];
		gh_c = gh_d[EXT_W-1] ? '0 : gh_d[LEN_W-1:0];
	end

	// ---------------------------------------------------------------------
	// Datapath helpers
	// ---------------------------------------------------------------------
	logic [UNI_W-1:0]  uni_d;
	logic              take_new;
	logic [AREA_W-1:0] bi_d;
	logic [UNI_W-1:0]  bu_d;
	logic              div_ge;
	logic [REM_W-1:0]  div_diff;
	logic              out_load;

	always_comb begin
		uni_d    = UNI_W'(dd_q) + UNI_W'(gg_q) - UNI_W'(ii_q);
		// strictly larger ratio and a non-empty union replace the best pair
		take_new = (uni_q != '0) && (acc_a_q > acc_b_q);
		bi_d     = take_new ? ii_q : bi_q;
		bu_d     = take_new ? uni_q : bu_q;
		div_ge   = rem_q >= REM_W'(bu_q);
		div_diff = rem_q - REM_W'(bu_q);
		out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	assign in_ready = (state_q == ST_IDLE);

	// ---------------------------------------------------------------------
	// Sequencer and control state
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			bi_q        <= '0;
			bu_q        <= UNI_W'(1);
			out_valid_q <= 1'b0;
			thr_q       <= miou_pkg::THRESH_RESET;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end

			// drop the result once taken, unless a new one lands
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						last_q  <= last_box;
						cnt_q   <= CNT_W'(LEN_W - 1);
						state_q <= ST_AREA;
					end
				end
				ST_AREA: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_UNION;
					end
				end
				ST_UNION: begin
					cnt_q   <= CNT_W'(UNI_W - 1);
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					bi_q <= bi_d;
					bu_q <= bu_d;
					if (last_q) begin
						cnt_q   <= CNT_W'(OUT_BITS - 1);
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register is free, then clear the group
					if (out_load) begin
						bi_q    <= '0;
						bu_q    <= UNI_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Serial datapath (payload, no reset)
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					iw_q <= iw_c;
					ih_q <= ih_c;
					dw_q <= LEN_W'(det_width);
					dh_q <= LEN_W'(det_height);
					gw_q <= gw_c;
					gh_q <= gh_c;
					ii_q <= '0;
					dd_q <= '0;
					gg_q <= '0;
				end
			end
			ST_AREA: begin
				// shift-add, multiplier MSB first
				ii_q <= (ii_q << 1) + (ih_q[LEN_W-1] ? AREA_W'(iw_q) : '0);
				dd_q <= (dd_q << 1) + (dh_q[LEN_W-1] ? AREA_W'(dw_q) : '0);
				gg_q <= (gg_q << 1) + (gh_q[LEN_W-1] ? AREA_W'(gw_q) : '0);
				ih_q <= ih_q << 1;
				dh_q <= dh_q << 1;
				gh_q <= gh_q << 1;
			end
			ST_UNION: begin
				uni_q   <= uni_d;
				mu_q    <= uni_d;
				mb_q    <= bu_q;
				acc_a_q <= '0;
				acc_b_q <= '0;
			end
			ST_CMP: begin
				// acc_a = inter * best_union, acc_b = best_inter * union
				acc_a_q <= (acc_a_q << 1) + (mb_q[UNI_W-1] ? PROD_W'(ii_q) : '0);
				acc_b_q <= (acc_b_q << 1) + (mu_q[UNI_W-1] ? PROD_W'(bi_q) : '0);
				mb_q    <= mb_q << 1;
				mu_q    <= mu_q << 1;
			end
			ST_DECIDE: begin
				// best ratio never exceeds one, so the first step yields the integer bit
				rem_q  <= REM_W'(bi_d);
				quot_q <= '0;
			end
			ST_DIV: begin
				rem_q  <= (div_ge ? div_diff : rem_q) << 1;
				quot_q <= {quot_q[OUT_BITS-2:0], div_ge};
			end
			ST_DONE: begin
				if (out_load) begin
					max_iou_q <= quot_q;
					below_q   <= (quot_q < thr_q);
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign max_iou         = max_iou_q;
	assign below_threshold = below_q;

endmodule

/* verif/max_iou_against_box_set_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_iou_against_box_set_unit_tb - self-checking bench for the max IoU unit
// Streams detection / ground-truth pairs in groups closed by last_box, tracks
// the best intersection / union pair of each group in a scoreboard, predicts
// the Q1.16 maximum IoU and the threshold flag, and checks every output
// transaction field by field under several threshold and idling settings.
// ----------------------------------------------------------------------------
module max_iou_against_box_set_unit_tb;

	localparam int COORD_BITS       = miou_pkg::COORD_BITS;
	localparam int SIZE_BITS        = miou_pkg::SIZE_BITS;
	localparam int OUT_BITS         = miou_pkg::OUT_BITS;
	localparam int FRACTION_BITS    = miou_pkg::FRACTION_BITS;
	localparam int COORD_MIN        = -(1 << (COORD_BITS - 1));
	localparam int COORD_MAX        = (1 << (COORD_BITS - 1)) - 1;
	localparam int SIZE_MAX         = (1 << SIZE_BITS) - 1;
	localparam int ITEMS_PER_PHASE  = 350;
	localparam int NUM_PHASES       = 5;
	// receiver hold-off long enough for the block to back up and stall input
	localparam int LONG_HOLD_CYCLES = 800;
	// settle time for a group-closing item, with margin on top
	localparam int SETTLE_CYCLES    = 80;
	localparam int CYCLE_LIMIT      = 1000000;

	// one input transaction
	typedef struct packed {
		logic signed [COORD_BITS-1:0] det_x;
		logic signed [COORD_BITS-1:0] det_y;
		logic        [SIZE_BITS-1:0]  det_width;
		logic        [SIZE_BITS-1:0]  det_height;
		logic signed [COORD_BITS-1:0] gt_left;
		logic signed [COORD_BITS-1:0] gt_top;
		logic signed [COORD_BITS-1:0] gt_right;
		logic signed [COORD_BITS-1:0] gt_bottom;
		logic                         last_box;
	} box_t;

	// one output transaction
	typedef struct packed {
		logic [OUT_BITS-1:0] max_iou;
		logic                below_threshold;
	} iou_result_t;

	// ------------------------------------------------------------------------
	// Scoreboard: running best ratio of the open group plus the queue of
	// group results still owed by the block.
	// ------------------------------------------------------------------------
	class best_iou_tracker;
		longint              best_inter;
		longint              best_uni;
		logic [OUT_BITS-1:0] threshold;
		iou_result_t         expected_iou_q[$];
		int unsigned         errors;

		function new();
			best_inter = 0;
			best_uni   = 1;
			threshold  = miou_pkg::THRESH_RESET;
			errors     = 0;
		endfunction

		function int pending();
			return expected_iou_q.size();
		endfunction

		task log_mismatch(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		// Fold one accepted box into the group; close the group on last_box.
		function void note_box(box_t b);
			longint      dx1, dy1, dx2, dy2;
			longint      gx1, gy1, gx2, gy2;
			longint      gw, gh, iw, ih, inter, uni, quot;
			iou_result_t want;
			dx1 = longint'($signed(b.det_x));
			dy1 = longint'($signed(b.det_y));
			dx2 = dx1 + longint'(b.det_width);
			dy2 = dy1 + longint'(b.det_height);
			gx1 = longint'($signed(b.gt_left));
			gy1 = longint'($signed(b.gt_top));
			gx2 = longint'($signed(b.gt_right));
			gy2 = longint'($signed(b.gt_bottom));
			// an inverted ground-truth box has zero area
			gw = (gx2 > gx1) ? gx2 - gx1 : 0;
			gh = (gy2 > gy1) ? gy2 - gy1 : 0;
			iw = ((dx2 < gx2) ? dx2 : gx2) - ((dx1 > gx1) ? dx1 : gx1);
			ih = ((dy2 < gy2) ? dy2 : gy2) - ((dy1 > gy1) ? dy1 : gy1);
			if (iw < 0)
				iw = 0;
			if (ih < 0)
				ih = 0;
			inter = iw * ih;
			uni   = longint'(b.det_width) * longint'(b.det_height) + gw * gh - inter;
			// empty union never wins; ties keep the earlier pair
			if (uni != 0 && inter * best_uni > best_inter * uni) begin
				best_inter = inter;
				best_uni   = uni;
			end
			if (b.last_box) begin
				quot = (best_inter << FRACTION_BITS) / best_uni;
				want.max_iou         = quot[OUT_BITS-1:0];
				want.below_threshold = (want.max_iou < threshold);
				expected_iou_q = {expected_iou_q, want};
				best_inter = 0;
				best_uni   = 1;
			end
		endfunction

		task check_iou(logic [OUT_BITS-1:0] iou, logic flag);
			iou_result_t want;
			if (expected_iou_q.size() == 0) begin
				log_mismatch($sformatf("result with nothing pending: max_iou %0d", iou));
				return;
			end
			want = expected_iou_q.pop_front();
			if (iou !== want.max_iou)
				log_mismatch($sformatf("max_iou got %0d want %0d", iou, want.max_iou));
			if (flag !== want.below_threshold)
				log_mismatch($sformatf("below_threshold got %0b want %0b (max_iou %0d)",
					flag, want.below_threshold, want.max_iou));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// DUT signals: every input holds a known value from time zero
	// ------------------------------------------------------------------------
	logic                         clk             = 1'b0;
	logic                         arst_n          = 1'b0;
	logic                         in_valid        = 1'b0;
	logic                         in_ready;
	logic signed [COORD_BITS-1:0] det_x           = '0;
	logic signed [COORD_BITS-1:0] det_y           = '0;
	logic        [SIZE_BITS-1:0]  det_width       = '0;
	logic        [SIZE_BITS-1:0]  det_height      = '0;
	logic signed [COORD_BITS-1:0] gt_left         = '0;
	logic signed [COORD_BITS-1:0] gt_top          = '0;
	logic signed [COORD_BITS-1:0] gt_right        = '0;
	logic signed [COORD_BITS-1:0] gt_bottom       = '0;
	logic                         last_box        = 1'b0;
	logic                         out_valid;
	logic                         out_ready       = 1'b0;
	logic        [OUT_BITS-1:0]   max_iou;
	logic                         below_threshold;
	logic                         cfg_wr_en       = 1'b0;
	logic        [OUT_BITS-1:0]   cfg_wr_data     = '0;

	// idling knobs, in percent of cycles
	int              send_idle_pct = 0;
	int              stall_pct     = 0;
	// set by the stimulus, consumed by the receiver process
	bit              hold_request  = 1'b0;
	int              cycle_count   = 0;
	best_iou_tracker tracker;

	max_iou_against_box_set_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.det_x           (det_x),
		.det_y           (det_y),
		.det_width       (det_width),
		.det_height      (det_height),
		.gt_left         (gt_left),
		.gt_top          (gt_top),
		.gt_right        (gt_right),
		.gt_bottom       (gt_bottom),
		.last_box        (last_box),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.max_iou         (max_iou),
		.below_threshold (below_threshold),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Abort a hung run; the limit is far above the slowest legal run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off on request. The hold is
	// counted here so the sender keeps offering items while results back up.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Check each output transaction against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_iou(max_iou, below_threshold);
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic signed [COORD_BITS-1:0] clamp_coord(input int v);
		if (v < COORD_MIN)
			v = COORD_MIN;
		else if (v > COORD_MAX)
			v = COORD_MAX;
		return v[COORD_BITS-1:0];
	endfunction

	function automatic int random_coord();
		return int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
	endfunction

	// mostly small boxes, a few huge ones, now and then a degenerate one
	function automatic int random_size();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0)
			return 0;
		if (pick == 1)
			return int'($urandom_range(SIZE_MAX));
		return int'($urandom_range(300));
	endfunction

	function automatic int jitter(input int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	function automatic box_t make_box(input int dx, input int dy, input int dw,
		input int dh, input int gl, input int gtp, input int gr, input int gb,
		input bit last);
		box_t b;
		b.det_x      = clamp_coord(dx);
		b.det_y      = clamp_coord(dy);
		b.det_width  = dw[SIZE_BITS-1:0];
		b.det_height = dh[SIZE_BITS-1:0];
		b.gt_left    = clamp_coord(gl);
		b.gt_top     = clamp_coord(gtp);
		b.gt_right   = clamp_coord(gr);
		b.gt_bottom  = clamp_coord(gb);
		b.last_box   = last;
		return b;
	endfunction

	// raw random bits in every field
	function automatic box_t noise_box();
		box_t b;
		b.det_x      = COORD_BITS'($urandom);
		b.det_y      = COORD_BITS'($urandom);
		b.det_width  = SIZE_BITS'($urandom);
		b.det_height = SIZE_BITS'($urandom);
		b.gt_left    = COORD_BITS'($urandom);
		b.gt_top     = COORD_BITS'($urandom);
		b.gt_right   = COORD_BITS'($urandom);
		b.gt_bottom  = COORD_BITS'($urandom);
		b.last_box   = 1'($urandom);
		return b;
	endfunction

	// Offer one transaction, idling first at the sender's rate, and hold it
	// until the block takes it.
	task automatic send_box(input box_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		det_x      <= b.det_x;
		det_y      <= b.det_y;
		det_width  <= b.det_width;
		det_height <= b.det_height;
		gt_left    <= b.gt_left;
		gt_top     <= b.gt_top;
		gt_right   <= b.gt_right;
		gt_bottom  <= b.gt_bottom;
		last_box   <= b.last_box;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_box(b);
	endtask

	// Drop valid and wait until every owed result has come back.
	task automatic wait_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	// Only called with the block idle.
	task automatic write_threshold(input logic [OUT_BITS-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.threshold = value;
	endtask

	// One detection against a group of ground-truth boxes. Most groups keep
	// one detection and place boxes around it (exact copies, near misses,
	// inverted and far boxes); some groups are pure noise.
	task automatic send_group(output int count);
		int   dx, dy, dw, dh;
		int   gl, gtp, gr, gb;
		int   pick;
		bit   noisy;
		box_t b;
		count = ($urandom_range(19) == 0) ? int'($urandom_range(8, 20))
			: int'($urandom_range(1, 6));
		noisy = ($urandom_range(4) == 0);
		dx    = random_coord();
		dy    = random_coord();
		dw    = random_size();
		dh    = random_size();
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (noisy || pick >= 95) begin
				b = noise_box();
			end else begin
				if (pick < 10) begin
					gl  = dx;
					gtp = dy;
					gr  = dx + dw;
					gb  = dy + dh;
				end else if (pick < 60) begin
					gl  = dx + jitter(dw / 2 + 8);
					gtp = dy + jitter(dh / 2 + 8);
					gr  = gl + dw + jitter(dw / 4 + 4);
					gb  = gtp + dh + jitter(dh / 4 + 4);
				end else if (pick < 75) begin
					// inverted in x, sometimes in y as well
					gl  = dx + jitter(dw / 2 + 8);
					gr  = gl - int'($urandom_range(1, 64));
					gtp = dy + jitter(dh / 2 + 8);
					gb  = ($urandom_range(1) == 0) ? gtp + dh
						: gtp - int'($urandom_range(1, 64));
				end else begin
					gl  = random_coord();
					gtp = random_coord();
					gr  = gl + random_size();
					gb  = gtp + random_size();
				end
				b = make_box(dx, dy, dw, dh, gl, gtp, gr, gb, 1'b0);
			end
			b.last_box = (k == count - 1);
			send_box(b);
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int  sent;
		int  group_len;
		bit  paused;
		tracker = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, threshold at its reset value.
		// identical boxes: IoU of exactly one
		send_box(make_box(0, 0, 100, 50, 0, 0, 100, 50, 1'b1));
		// full coordinate range on the ground truth, largest detection at the low corner
		send_box(make_box(COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
			COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1));
		// detection reaching past the coordinate range, touching only the edge
		send_box(make_box(COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX,
			COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1));
		send_box(make_box(4000, 4000, SIZE_MAX, SIZE_MAX, 3000, 3000, COORD_MAX,
			COORD_MAX, 1'b1));
		// inverted ground-truth box
		send_box(make_box(0, 0, 10, 10, 10, 10, 0, 0, 1'b1));
		// empty union alone, then followed by a real box
		send_box(make_box(5, 5, 0, 0, 10, 10, 10, 10, 1'b1));
		send_box(make_box(5, 5, 0, 0, 3, 3, 1, 1, 1'b0));
		send_box(make_box(0, 0, 10, 10, 0, 0, 5, 10, 1'b1));
		// three boxes with equal ratio: first one stays
		send_box(make_box(0, 0, 10, 10, 0, 0, 5, 10, 1'b0));
		send_box(make_box(0, 0, 10, 10, 5, 0, 10, 10, 1'b0));
		send_box(make_box(0, 0, 10, 10, 0, 0, 10, 5, 1'b1));
		// best box in the middle of the group
		send_box(make_box(0, 0, 30, 30, 20, 20, 40, 40, 1'b0));
		send_box(make_box(0, 0, 30, 30, 1, 1, 30, 30, 1'b0));
		send_box(make_box(0, 0, 30, 30, -100, -100, -50, -50, 1'b1));
		// zero-width detection
		send_box(make_box(0, 0, 0, 20, 0, 0, 10, 10, 1'b1));
		// truncation of the fraction, both sides of the threshold
		send_box(make_box(0, 0, 3, 1, 0, 0, 1, 1, 1'b1));
		send_box(make_box(0, 0, 7, 1, 0, 0, 2, 1, 1'b1));
		// tiny detection inside the largest ground-truth box
		send_box(make_box(0, 0, 1, 1, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
			1'b1));
		// opposite corner extremes
		send_box(make_box(COORD_MIN, COORD_MAX, SIZE_MAX, 0, COORD_MAX, COORD_MIN,
			COORD_MIN, COORD_MAX, 1'b1));

		// Random phases, each with its own threshold and idling mix.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			// drain and let the block finish any item that owes no result
			wait_results();
			repeat (SETTLE_CYCLES) @(posedge clk);
			case (phase)
				0: begin
					write_threshold('0);
					send_idle_pct = 0;
					stall_pct     = 0;
					hold_request  = 1'b1;
				end
				1: begin
					write_threshold(OUT_BITS'(65536));
					send_idle_pct = 61;
					stall_pct     = 0;
				end
				2: begin
					// above one: every group is flagged
					write_threshold('1);
					send_idle_pct = 0;
					stall_pct     = 61;
				end
				3: begin
					write_threshold(OUT_BITS'($urandom_range(65536)));
					send_idle_pct = 36;
					stall_pct     = 36;
				end
				default: begin
					write_threshold(OUT_BITS'(32768));
				end
			endcase
			sent   = 0;
			paused = 1'b0;
			while (sent < ITEMS_PER_PHASE) begin
				// last phase: flip idling per group
				if (phase == NUM_PHASES - 1) begin
					send_idle_pct = ($urandom_range(1) == 0) ? 0 : 61;
					stall_pct     = ($urandom_range(1) == 0) ? 0 : 61;
				end
				// hold the sender mid-phase until the block has drained
				if (phase == 3 && !paused && sent >= ITEMS_PER_PHASE / 2) begin
					wait_results();
					paused = 1'b1;
				end
				send_group(group_len);
				sent += group_len;
			end
		end

		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* sim.f */
design/miou_pkg.sv
design/max_iou_against_box_set_unit.sv
verif/max_iou_against_box_set_unit_tb.sv
